FILE: hdl/ami3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami3_pkg
// Shared types and constants of the 3x3 affine matrix inverse unit.
// ----------------------------------------------------------------------------
package ami3_pkg;

  localparam int ENTRY_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_BITS = 32;
  localparam int LANES      = 9;

  localparam int PROD_W = 2 * ENTRY_BITS;
  localparam int COF_W  = 2 * ENTRY_BITS + 1;
  localparam int DET_W  = 3 * ENTRY_BITS + 2;
  localparam int QUO_W  = ENTRY_BITS + 1;
  localparam int REM_W  = 4 * ENTRY_BITS + 3;
  localparam int LO_W   = ENTRY_BITS + 2;

  typedef logic [3:0] idx_t;

  // cofactor k = +/-(a[P0]*a[P1] - a[Q0]*a[Q1])
  localparam idx_t COF_P0 [LANES] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
  localparam idx_t COF_P1 [LANES] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
  localparam idx_t COF_Q0 [LANES] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
  localparam idx_t COF_Q1 [LANES] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
  localparam logic [LANES-1:0] COF_FLIP = 9'b010101010;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] a00;
    logic signed [FIELD_BITS-1:0] a01;
    logic signed [FIELD_BITS-1:0] a02;
    logic signed [FIELD_BITS-1:0] a10;
    logic signed [FIELD_BITS-1:0] a11;
    logic signed [FIELD_BITS-1:0] a12;
    logic signed [FIELD_BITS-1:0] a20;
    logic signed [FIELD_BITS-1:0] a21;
    logic signed [FIELD_BITS-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] inv00;
    logic signed [FIELD_BITS-1:0] inv01;
    logic signed [FIELD_BITS-1:0] inv02;
    logic signed [FIELD_BITS-1:0] inv10;
    logic signed [FIELD_BITS-1:0] inv11;
    logic signed [FIELD_BITS-1:0] inv12;
    logic signed [FIELD_BITS-1:0] inv20;
    logic signed [FIELD_BITS-1:0] inv21;
    logic signed [FIELD_BITS-1:0] inv22;
    logic                         singular;
  } out_t;

  // one request moving down the divider chain
  typedef struct packed {
    logic                              valid;
    logic                              singular;
    logic [LANES-1:0]                  neg;
    logic [LANES-1:0]                  ovf;
    logic [REM_W-1:0]                  dsh;
    logic [LANES-1:0][REM_W-1:0]       rem;
    logic [LANES-1:0][QUO_W-1:0]       quo;
  } lane_t;

endpackage

FILE: hdl/affine_matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_3x3_unit
// 3x3 Q16.16 matrix inverse by adjugate, exact determinant, saturated output.
// ----------------------------------------------------------------------------
// Takes one matrix per cycle unless stalled and returns its inverse through a
// multiply/add pipeline for the cofactors and the determinant, a chain of
// 33 division cells that each resolve one quotient bit for all nine
// entries, and a saturation step into the output register. The whole
// pipeline advances together; a stall on the output freezes it, so in_stall
// is high exactly while a finished result waits under out_stall.
module affine_matrix_inverse_3x3_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ami3_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ami3_pkg::out_t out_data
);

  localparam int NC = ami3_pkg::QUO_W;

  logic            en;
  ami3_pkg::lane_t chain [NC+1];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  ami3_cof u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .lane     (chain[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    ami3_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  ami3_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .din       (chain[NC]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/ami3_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami3_cof
// Front pipeline: cofactors, determinant and divider operand setup.
// ----------------------------------------------------------------------------
module ami3_cof (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ami3_pkg::in_t in_data,
  output ami3_pkg::lane_t lane
);

  localparam int EB = ami3_pkg::ENTRY_BITS;
  localparam int N  = ami3_pkg::LANES;

  logic [N-1:0][EB-1:0] a_in;
  logic [4:0]           v_r;

  logic [N-1:0][ami3_pkg::PROD_W-1:0] pa_nxt, pb_nxt, pa_r, pb_r;
  logic [2:0][EB-1:0]                 col1_r, col2_r;
  logic [N-1:0][ami3_pkg::COF_W-1:0]  cof2_nxt, cof2_r, cof3_r, cof4_r;
  logic [2:0][ami3_pkg::PROD_W-1:0]   mh_nxt, mh_r;
  logic [2:0][ami3_pkg::LO_W+EB-1:0]  ml_nxt, ml_r;
  logic [ami3_pkg::DET_W-1:0]         det_nxt, det_r;
  ami3_pkg::lane_t                    lane_nxt, lane_r;

  assign a_in[0] = in_data.a00[EB-1:0];
  assign a_in[1] = in_data.a01[EB-1:0];
  assign a_in[2] = in_data.a02[EB-1:0];
  assign a_in[3] = in_data.a10[EB-1:0];
  assign a_in[4] = in_data.a11[EB-1:0];
  assign a_in[5] = in_data.a12[EB-1:0];
  assign a_in[6] = in_data.a20[EB-1:0];
  assign a_in[7] = in_data.a21[EB-1:0];
  assign a_in[8] = in_data.a22[EB-1:0];

  always_comb begin
    logic signed [ami3_pkg::PROD_W-1:0] ta, tb;
    for (int k = 0; k < N; k++) begin
      ta = $signed(a_in[ami3_pkg::COF_P0[k]]) * $signed(a_in[ami3_pkg::COF_P1[k]]);
      tb = $signed(a_in[ami3_pkg::COF_Q0[k]]) * $signed(a_in[ami3_pkg::COF_Q1[k]]);
      pa_nxt[k] = ta;
      pb_nxt[k] = tb;
    end
  end

  always_comb begin
    logic signed [ami3_pkg::COF_W-1:0] tc;
    for (int k = 0; k < N; k++) begin
      tc = $signed(pa_r[k]) - $signed(pb_r[k]);
      if (ami3_pkg::COF_FLIP[k]) begin
        tc = -tc;
      end
      cof2_nxt[k] = tc;
    end
  end

  // det terms split as a*c_hi*2^(EB+1) + a*c_lo
  always_comb begin
    logic signed [ami3_pkg::PROD_W-1:0]    th;
    logic signed [ami3_pkg::LO_W+EB-1:0]   tl;
    for (int j = 0; j < 3; j++) begin
      th = $signed(col2_r[j]) * $signed(cof2_r[j][ami3_pkg::COF_W-1:EB+1]);
      tl = $signed(col2_r[j]) * $signed({1'b0, cof2_r[j][EB:0]});
      mh_nxt[j] = th;
      ml_nxt[j] = tl;
    end
  end

  always_comb begin
    logic signed [ami3_pkg::DET_W-1:0] acc, tw;
    acc = '0;
    for (int j = 0; j < 3; j++) begin
      tw  = $signed(mh_r[j]);
      acc = acc + (tw <<< (EB + 1)) + $signed(ml_r[j]);
    end
    det_nxt = acc;
  end

  always_comb begin
    logic                           dneg, cneg;
    logic [ami3_pkg::DET_W-1:0]     dm;
    logic [ami3_pkg::COF_W-1:0]     cm;
    logic [ami3_pkg::REM_W-1:0]     dw, nw;
    dneg = det_r[ami3_pkg::DET_W-1];
    dm   = dneg ? -det_r : det_r;
    dw   = ami3_pkg::REM_W'(dm);
    lane_nxt          = '0;
    lane_nxt.singular = (det_r == '0);
    lane_nxt.dsh      = dw << (ami3_pkg::QUO_W - 1);
    for (int k = 0; k < N; k++) begin
      cneg = cof4_r[k][ami3_pkg::COF_W-1];
      cm   = cneg ? -cof4_r[k] : cof4_r[k];
      nw   = ami3_pkg::REM_W'(cm) << (2 * ami3_pkg::FRAC_BITS);
      lane_nxt.neg[k] = cneg ^ dneg;
      lane_nxt.ovf[k] = (nw >= (dw << ami3_pkg::QUO_W));
      lane_nxt.rem[k] = nw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      col1_r <= {a_in[6], a_in[3], a_in[0]};
      cof2_r <= cof2_nxt;
      col2_r <= col1_r;
      mh_r   <= mh_nxt;
      ml_r   <= ml_nxt;
      cof3_r <= cof2_r;
      det_r  <= det_nxt;
      cof4_r <= cof3_r;
      lane_r <= lane_nxt;
    end
  end

  always_comb begin
    lane       = lane_r;
    lane.valid = v_r[4];
  end

endmodule

FILE: hdl/ami3_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami3_div_cell
// One restoring division step for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module ami3_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ami3_pkg::lane_t din,
  output ami3_pkg::lane_t dout
);

  ami3_pkg::lane_t nxt, dout_r;
  logic            v_r;

  always_comb begin
    logic hit;
    nxt     = din;
    nxt.dsh = din.dsh >> 1;
    for (int k = 0; k < ami3_pkg::LANES; k++) begin
      hit = (din.rem[k] >= din.dsh);
      if (hit) begin
        nxt.rem[k] = din.rem[k] - din.dsh;
      end
      nxt.quo[k] = {din.quo[k][ami3_pkg::QUO_W-2:0], hit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= nxt;
    end
  end

  always_comb begin
    dout       = dout_r;
    dout.valid = v_r;
  end

endmodule

FILE: hdl/ami3_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ami3_sat
// Sign, saturation and singular masking; holds the output register.
// ----------------------------------------------------------------------------
module ami3_sat (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ami3_pkg::lane_t din,
  output logic            out_valid,
  output ami3_pkg::out_t  out_data
);

  localparam int EB = ami3_pkg::ENTRY_BITS;
  localparam int QW = ami3_pkg::QUO_W;

  ami3_pkg::out_t out_nxt, out_r;
  logic           v_r;
  logic [ami3_pkg::LANES-1:0][ami3_pkg::FIELD_BITS-1:0] fld;

  always_comb begin
    logic [QW-1:0]                      lim, q, mag;
    logic [EB-1:0]                      val;
    logic signed [ami3_pkg::FIELD_BITS-1:0] f;
    lim = QW'(1) << (EB - 1);
    for (int k = 0; k < ami3_pkg::LANES; k++) begin
      q = din.quo[k];
      if (din.neg[k]) begin
        mag = (din.ovf[k] || q > lim) ? lim : q;
      end else begin
        mag = (din.ovf[k] || q > lim - 1'b1) ? lim - 1'b1 : q;
      end
      val = mag[EB-1:0];
      if (din.neg[k]) begin
        val = -val;
      end
      if (din.singular) begin
        val = '0;
      end
      f      = $signed(val);
      fld[k] = f;
    end
    out_nxt.inv00    = fld[0];
    out_nxt.inv01    = fld[1];
    out_nxt.inv02    = fld[2];
    out_nxt.inv10    = fld[3];
    out_nxt.inv11    = fld[4];
    out_nxt.inv12    = fld[5];
    out_nxt.inv20    = fld[6];
    out_nxt.inv21    = fld[7];
    out_nxt.inv22    = fld[8];
    out_nxt.singular = din.singular;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = out_r;

endmodule
